// ===== rtl/packet_to_frame_reassembly_tracker_macros.svh =====
// Assertion macros for the packet reassembly tracker.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef PACKET_TO_FRAME_REASSEMBLY_TRACKER_MACROS_SVH
`define PACKET_TO_FRAME_REASSEMBLY_TRACKER_MACROS_SVH

// condition implies consequence in the same cycle
`define PRTK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PRTK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/prtk_pkg.sv =====
// Shared types and constants for the packet reassembly tracker.
// No dependencies; imported by every module of the block.
package prtk_pkg;

  localparam int MaxPackets = 1024;
  localparam int IdxW       = $clog2(MaxPackets);
  localparam int CntW       = IdxW + 1;
  localparam int RowBits    = 8;
  localparam int BitW       = $clog2(RowBits);
  localparam int RowCnt     = MaxPackets / RowBits;
  localparam int ProdW      = IdxW + 16;
  localparam int EndW       = ProdW + 1;

  localparam logic CfgFrameLimit = 1'b0;
  localparam logic CfgSlotStride = 1'b1;

  typedef enum logic [1:0] {
    ReqStart  = 2'd0,
    ReqPacket = 2'd1,
    ReqClear  = 2'd2,
    ReqNone   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    StStarted       = 3'd0,
    StAccepted      = 3'd1,
    StIdRange       = 3'd2,
    StDuplicate     = 3'd3,
    StOversize      = 3'd4,
    StCleared       = 3'd5,
    StCountTooLarge = 3'd6,
    StUnused        = 3'd7
  } status_e;

  typedef struct packed {
    req_e               req;
    logic [31:0]        fid;
    logic [15:0]        cnt;
    logic [15:0]        pid;
    logic [15:0]        len;
    logic [ProdW-1:0]   prod;
  } item_t;

  typedef struct packed {
    logic set;
    logic clear_all;
  } map_upd_t;

  // member order gives the tdata layout, status in the low bits
  typedef struct packed {
    logic [3:0]      pad;
    logic [31:0]     current_frame;
    logic            any_received;
    logic            frame_has_gap;
    logic            frame_complete;
    logic [23:0]     frame_bytes;
    logic [CntW-1:0] expected_total;
    logic [CntW-1:0] received_total;
    logic [15:0]     write_length;
    logic [23:0]     write_offset;
    status_e         status;
  } result_t;

endpackage

// ===== rtl/prtk_seen_map.sv =====
// Received-packet bitmap: 128 x 8 memory with per-row valid flops.
// Depends on prtk_pkg.
module prtk_seen_map (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [prtk_pkg::IdxW-1:0] rd_idx_i,
  input  prtk_pkg::map_upd_t       upd_i,
  output logic                     seen_o
);
  import prtk_pkg::*;

  logic [RowBits-1:0] mem [RowCnt];
  logic [RowBits-1:0] rdata_q;
  logic [RowBits-1:0] fwd_data_q;
  logic               fwd_hit_q;
  logic [IdxW-1:0]    rd_idx_q;
  logic [RowCnt-1:0]  valid_q;

  logic [IdxW-BitW-1:0] cur_row;
  logic [RowBits-1:0]   row_eff;
  logic [RowBits-1:0]   wr_data;

  assign cur_row = rd_idx_q[IdxW-1:BitW];

  // an invalid row reads as empty; a write on the edge of the read is forwarded
  always_comb begin
    if (!valid_q[cur_row]) begin
      row_eff = '0;
    end else if (fwd_hit_q) begin
      row_eff = fwd_data_q;
    end else begin
      row_eff = rdata_q;
    end
    wr_data = row_eff | (RowBits'(1) << rd_idx_q[BitW-1:0]);
  end

  assign seen_o = row_eff[rd_idx_q[BitW-1:0]];

  always_ff @(posedge clk_i) begin
    if (upd_i.set) begin
      mem[cur_row] <= wr_data;
    end
    if (rd_en_i) begin
      rdata_q    <= mem[rd_idx_i[IdxW-1:BitW]];
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      fwd_hit_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      if (upd_i.clear_all) begin
        valid_q <= '0;
      end else if (upd_i.set) begin
        valid_q[cur_row] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_idx_q  <= rd_idx_i;
        fwd_hit_q <= upd_i.set && (cur_row == rd_idx_i[IdxW-1:BitW]);
      end
    end
  end

endmodule

// ===== rtl/prtk_track.sv =====
// Frame state and per-word decision: checks, counters, high-water mark.
// Depends on prtk_pkg.
module prtk_track (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  prtk_pkg::item_t    item_i,
  input  logic               seen_i,
  input  logic [23:0]        frame_limit_i,
  output prtk_pkg::map_upd_t upd_o,
  output logic               res_valid_o,
  output prtk_pkg::result_t  res_o
);
  import prtk_pkg::*;

  logic [CntW-1:0] seen_cnt_q, seen_cnt_d;
  logic [CntW-1:0] exp_cnt_q, exp_cnt_d;
  logic [23:0]     hw_q, hw_d;
  logic [31:0]     fid_q, fid_d;

  logic [EndW-1:0] end_sum;
  status_e         status;
  logic [23:0]     woff;
  logic [15:0]     wlen;
  logic            do_set;
  logic            do_clr;

  assign end_sum = EndW'(item_i.prod) + EndW'(item_i.len);

  always_comb begin
    seen_cnt_d  = seen_cnt_q;
    exp_cnt_d   = exp_cnt_q;
    hw_d        = hw_q;
    fid_d       = fid_q;
    status      = StStarted;
    woff        = '0;
    wlen        = '0;
    do_set      = 1'b0;
    do_clr      = 1'b0;
    res_valid_o = 1'b1;
    unique case (item_i.req)
      ReqStart: begin
        if (item_i.cnt > 16'(MaxPackets)) begin
          status = StCountTooLarge;
        end else begin
          fid_d      = item_i.fid;
          exp_cnt_d  = item_i.cnt[CntW-1:0];
          seen_cnt_d = '0;
          hw_d       = '0;
          do_clr     = 1'b1;
          status     = StStarted;
        end
      end
      ReqPacket: begin
        // expected never exceeds the map size, so this also bounds the id
        priority if (item_i.pid >= 16'(exp_cnt_q)) begin
          status = StIdRange;
        end else if (seen_i) begin
          status = StDuplicate;
        end else if (end_sum > EndW'(frame_limit_i)) begin
          status = StOversize;
        end else begin
          status     = StAccepted;
          do_set     = 1'b1;
          seen_cnt_d = seen_cnt_q + CntW'(1);
          if (end_sum > EndW'(hw_q)) begin
            hw_d = end_sum[23:0];
          end
          woff = item_i.prod[23:0];
          wlen = item_i.len;
        end
      end
      ReqClear: begin
        exp_cnt_d  = '0;
        seen_cnt_d = '0;
        do_clr     = 1'b1;
        status     = StCleared;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  assign upd_o.set       = adv_i && do_set;
  assign upd_o.clear_all = adv_i && do_clr;

  always_comb begin
    res_o                = '0;
    res_o.status         = status;
    res_o.write_offset   = woff;
    res_o.write_length   = wlen;
    res_o.received_total = seen_cnt_d;
    res_o.expected_total = exp_cnt_d;
    res_o.frame_bytes    = hw_d;
    res_o.frame_complete = (seen_cnt_d == exp_cnt_d);
    res_o.frame_has_gap  = (seen_cnt_d < exp_cnt_d);
    res_o.any_received   = (seen_cnt_d != '0);
    res_o.current_frame  = fid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_cnt_q <= '0;
      exp_cnt_q  <= '0;
      hw_q       <= '0;
      fid_q      <= '0;
    end else if (adv_i) begin
      seen_cnt_q <= seen_cnt_d;
      exp_cnt_q  <= exp_cnt_d;
      hw_q       <= hw_d;
      fid_q      <= fid_d;
    end
  end

endmodule

// ===== rtl/packet_to_frame_reassembly_tracker.sv =====
// Top level of the packet reassembly tracker: input and result registers,
// config registers. Depends on prtk_pkg, prtk_seen_map, prtk_track, macros header.
//
//   channel   dir  width        holds
//   s_axis    in   80 + user 2  one request word
//   m_axis    out  128          one result word per request (none for unused kind)
//   cfg       in   1 + 24       frame limit / slot stride writes
//
// Slot product and bitmap row read are registered at accept; the decision on them
// is registered into the result register. One word per cycle while results do
// not stall; the bitmap row read-modify-write sets the pace.
// Reset clears bitmap row flags at once, so no clearing pass is needed.
// A stalled result holds a waiting input word and drops s_axis_tready.
`include "packet_to_frame_reassembly_tracker_macros.svh"

module packet_to_frame_reassembly_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // new_frame_id[31:0], expected_packets_in[47:32], packet_index[63:48],
  // payload_length[79:64]
  input  logic [79:0]   s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status[2:0], write_offset[26:3], write_length[42:27], received_total[53:43],
  // expected_total[64:54], frame_bytes[88:65], frame_complete[89],
  // frame_has_gap[90], any_received[91], current_frame[123:92], zero[127:124]
  output logic [127:0]  m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [23:0]   cfg_wdata_i
);
  import prtk_pkg::*;

  logic [23:0] frame_limit_q;
  logic [15:0] slot_stride_q;

  item_t    in_item;
  item_t    s1_q;
  logic     s1_valid_q;
  logic     s1_adv;
  logic     accept;
  logic     seen;
  map_upd_t upd;
  logic     res_valid;
  result_t  res;
  result_t  m_res_q;
  logic     m_valid_q;

  always_comb begin
    in_item.req  = req_e'(s_axis_tuser);
    in_item.fid  = s_axis_tdata[31:0];
    in_item.cnt  = s_axis_tdata[47:32];
    in_item.pid  = s_axis_tdata[63:48];
    in_item.len  = s_axis_tdata[79:64];
    in_item.prod = ProdW'(s_axis_tdata[48 +: IdxW]) * ProdW'(slot_stride_q);
  end

  assign s1_adv        = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= 24'hFFFFFF;
      slot_stride_q <= 16'd1472;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFrameLimit: frame_limit_q <= cfg_wdata_i;
        CfgSlotStride: slot_stride_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_item;
    end
    if (s1_valid_q && s1_adv) begin
      m_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_adv) begin
        m_valid_q <= res_valid;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  prtk_seen_map u_seen_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_idx_i (in_item.pid[IdxW-1:0]),
    .upd_i    (upd),
    .seen_o   (seen)
  );

  prtk_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (s1_valid_q && s1_adv),
    .item_i        (s1_q),
    .seen_i        (seen),
    .frame_limit_i (frame_limit_q),
    .upd_o         (upd),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  `PRTK_ASSERT_NOW(a_rx_le_exp, m_valid_q, m_res_q.received_total <= m_res_q.expected_total, "received count above expected")
  `PRTK_ASSERT_NOW(a_acc_any, m_valid_q && (m_res_q.status == StAccepted), m_res_q.any_received, "accepted word but nothing received")
  `PRTK_ASSERT_NOW(a_stall_blocks, s1_valid_q && m_valid_q && !m_axis_tready, !s_axis_tready, "input taken while result stalled")
  `PRTK_ASSERT_NEXT(a_clr_empty, upd.clear_all, m_valid_q && (m_res_q.received_total == '0), "clear not applied")

endmodule

// ===== tb/tb_packet_to_frame_reassembly_tracker.sv =====
// Self-checking testbench for packet_to_frame_reassembly_tracker: directed and random
// start/packet/clear words checked against an in-bench tracker model.
// Depends on prtk_pkg and the tracker RTL only.
module tb_packet_to_frame_reassembly_tracker;
  import prtk_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 250;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [79:0]   s_axis_tdata = '0;
  logic [1:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [127:0]  m_axis_tdata;
  logic          cfg_we_i = 1'b0;
  logic          cfg_idx_i = 1'b0;
  logic [23:0]   cfg_wdata_i = '0;

  logic          sink_hold = 1'b0;
  int            src_idle_pct = 21;
  int            sink_idle_pct = 62;
  int            stall_cycles = 0;
  int            errors = 0;
  int            words_sent = 0;
  int            results_seen = 0;
  int            packets_placed = 0;
  int            frames_done = 0;

  // tracker model state
  bit [MaxPackets-1:0] seen_bits = '0;
  logic [10:0]   rx_count = '0;
  logic [10:0]   exp_count = '0;
  logic [23:0]   high_water = '0;
  logic [31:0]   track_fid = '0;
  logic [23:0]   limit_cfg = 24'hFFFFFF;
  logic [15:0]   stride_cfg = 16'd1472;

  result_t       awaited_results[$];

  packet_to_frame_reassembly_tracker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  // updates the model for one accepted word and queues the result it should give
  task automatic apply_request(input req_e rq, input logic [31:0] fid, input logic [15:0] cnt,
                               input logic [15:0] pid, input logic [15:0] len);
    result_t     r;
    logic [31:0] slot_off;
    logic [31:0] slot_end;
    r = '0;
    case (rq)
      ReqStart: begin
        if (cnt > MaxPackets) begin
          r.status = StCountTooLarge;
        end else begin
          track_fid  = fid;
          exp_count  = cnt[10:0];
          rx_count   = '0;
          high_water = '0;
          seen_bits  = '0;
          r.status   = StStarted;
        end
      end
      ReqPacket: begin
        if (pid >= exp_count || pid >= MaxPackets) begin
          r.status = StIdRange;
        end else if (seen_bits[pid[9:0]]) begin
          r.status = StDuplicate;
        end else begin
          slot_off = 32'(pid) * 32'(stride_cfg);
          slot_end = slot_off + 32'(len);
          if (slot_end > 32'(limit_cfg)) begin
            r.status = StOversize;
          end else begin
            seen_bits[pid[9:0]] = 1'b1;
            rx_count = rx_count + 11'd1;
            if (slot_end > 32'(high_water)) high_water = slot_end[23:0];
            r.write_offset = slot_off[23:0];
            r.write_length = len;
            r.status = StAccepted;
          end
        end
      end
      ReqClear: begin
        exp_count = '0;
        rx_count  = '0;
        seen_bits = '0;
        r.status  = StCleared;
      end
      default: return;  // unused kind: no result
    endcase
    r.received_total = rx_count;
    r.expected_total = exp_count;
    r.frame_bytes    = high_water;
    r.frame_complete = (rx_count == exp_count);
    r.frame_has_gap  = (rx_count < exp_count);
    r.any_received   = (rx_count != 0);
    r.current_frame  = track_fid;
    awaited_results.push_back(r);
  endtask

  task automatic send_word(input req_e rq, input logic [31:0] fid, input logic [15:0] cnt,
                           input logic [15:0] pid, input logic [15:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, pid, cnt, fid};
    s_axis_tuser  <= rq;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(rq, fid, cnt, pid, len);
    if (rq != ReqNone) words_sent++;
  endtask

  // fields a request kind does not use carry random junk
  task automatic start_frame(input logic [31:0] fid, input logic [15:0] cnt);
    send_word(ReqStart, fid, cnt, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_packet(input logic [15:0] pid, input logic [15:0] len);
    send_word(ReqPacket, $urandom, 16'($urandom), pid, len);
  endtask

  task automatic send_clear();
    send_word(ReqClear, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_none();
    send_word(ReqNone, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // sender pauses until the last result is out, plus pipeline slack for unused words
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [23:0] limit, input logic [15:0] stride);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgFrameLimit;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_idx_i   <= CfgSlotStride;
    cfg_wdata_i <= {8'h00, stride};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_cfg   = limit;
    stride_cfg  = stride;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result word, status %0d", got.status);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("write_offset", 32'(want.write_offset), 32'(got.write_offset));
        check_field("write_length", 32'(want.write_length), 32'(got.write_length));
        check_field("received_total", 32'(want.received_total), 32'(got.received_total));
        check_field("expected_total", 32'(want.expected_total), 32'(got.expected_total));
        check_field("frame_bytes", 32'(want.frame_bytes), 32'(got.frame_bytes));
        check_field("frame_complete", 32'(want.frame_complete), 32'(got.frame_complete));
        check_field("frame_has_gap", 32'(want.frame_has_gap), 32'(got.frame_has_gap));
        check_field("any_received", 32'(want.any_received), 32'(got.any_received));
        check_field("current_frame", want.current_frame, got.current_frame);
        if (got.status == StAccepted) packets_placed++;
        if (got.status == StAccepted && got.frame_complete) frames_done++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // empty tracker after reset: every packet is out of range, frame reads complete
  task automatic test_empty_tracker();
    send_packet(16'd0, 16'd100);
    send_clear();
    send_none();
  endtask

  task automatic test_frame_starts();
    start_frame(32'hFFFF_FFFF, 16'hFFFF);
    start_frame(32'h1234_5678, 16'd1025);
    start_frame(32'h0000_0000, 16'd0);
    send_packet(16'd0, 16'd0);
    start_frame(32'hFFFF_FFFF, 16'd1024);
  endtask

  task automatic test_packet_checks();
    send_packet(16'd1023, 16'hFFFF);
    send_packet(16'd0, 16'd0);
    send_packet(16'd0, 16'd5);        // duplicate
    send_packet(16'd1024, 16'd1);
    send_packet(16'hFFFF, 16'hFFFF);
    send_packet(16'h5555, 16'hAAAA);
  endtask

  // clear drops counts but frame size and id stay
  task automatic test_clear_keeps_frame();
    send_clear();
    send_packet(16'd0, 16'd10);
    start_frame(32'hA5A5_5A5A, 16'd2);
    send_packet(16'd1, 16'd700);
    send_packet(16'd0, 16'd1472);
  endtask

  task automatic test_config_extremes();
    wait_results_drained();
    write_config(24'd0, 16'd0);
    start_frame(32'h0000_00C3, 16'd4);
    send_packet(16'd3, 16'd0);
    send_packet(16'd2, 16'd1);        // oversize against zero limit
    wait_results_drained();
    write_config(24'hFFFFFF, 16'hFFFF);
    start_frame(32'h8000_0001, 16'd1024);
    send_packet(16'd1023, 16'd0);     // slot end past the limit
    send_packet(16'd256, 16'd0);
    send_packet(16'd255, 16'hFFFF);
    wait_results_drained();
    write_config(24'hFFFFFF, 16'd1472);
  endtask

  // output held off while the input keeps offering, so the input must stall
  task automatic test_backpressure();
    start_frame($urandom, 16'd64);
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
      begin
        for (int i = 0; i < 40; i++) send_packet(16'(i), pick_len());
      end
    join
    wait_results_drained();
  endtask

  task automatic run_frame();
    int unsigned cnt;
    int unsigned r;
    int unsigned j;
    int unsigned tmp;
    int unsigned order[$];
    r = $urandom_range(99);
    if (r < 5) cnt = $urandom_range(1025, 65535);
    else if (r < 10) cnt = 0;
    else if (r < 16) cnt = $urandom_range(200, 1024);
    else cnt = $urandom_range(1, 24);
    start_frame($urandom, 16'(cnt));
    if (cnt > MaxPackets) return;
    if (cnt == 0) begin
      send_packet(16'($urandom), pick_len());
      return;
    end
    if (cnt > 48) begin
      for (int i = 0; i < 48; i++) order.push_back($urandom_range(0, cnt - 1));
    end else begin
      for (int i = 0; i < cnt; i++) order.push_back(i);
      for (int i = cnt - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    while (order.size() != 0) begin
      r = $urandom_range(99);
      if (r < 78) send_packet(16'(order.pop_front()), pick_len());
      else if (r < 86) send_packet(16'($urandom_range(0, cnt - 1)), pick_len());
      else if (r < 92) send_packet(16'($urandom_range(cnt, 65535)), pick_len());
      else if (r < 96) send_none();
      else if (r < 98) wait_results_drained();
      else begin
        send_clear();
        return;
      end
    end
  endtask

  task automatic test_random();
    int goal;
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct  = (mode == 0) ? 21 : (mode == 1) ? 62 : 0;
      sink_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 21 : 0;
      for (int round = 0; round < 3; round++) begin
        wait_results_drained();
        case ($urandom_range(4))
          0, 1: write_config(24'hFFFFFF, 16'd1472);
          2:    write_config(24'($urandom), 16'($urandom));
          3:    write_config(24'($urandom_range(0, 70000)), 16'($urandom_range(0, 100)));
          default: write_config(24'hFFFFFF, 16'hFFFF);
        endcase
        goal = words_sent + 155;
        while (words_sent < goal) run_frame();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_tracker();
    test_frame_starts();
    test_packet_checks();
    test_clear_keeps_frame();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_results_drained();
    $display("Ran %0d request words, %0d results checked: %0d packets placed, %0d frames done.",
             words_sent, results_seen, packets_placed, frames_done);
    $display("Included count overflow, empty frames, duplicates, clears, limit/stride extremes.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
